// ===== src/shabsh_pkg.sv =====
// ----------------------------------------------------------------------------
// shabsh_pkg
// Types, constants and round functions of the SHA-256 byte-stream hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package shabsh_pkg;

  // Command codes of an input request
  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  // Padding marker byte, the block offset where the length field starts, and the last byte, round and word indices
  localparam logic [7:0] PAD_MARKER  = 8'h80;
  localparam logic [5:0] LEN_POS     = 6'd56;
  localparam logic [5:0] LAST_BYTE   = 6'd63;
  localparam logic [5:0] LAST_ROUND  = 6'd63;
  localparam logic [2:0] LAST_WORD   = 3'd7;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_req_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic        word_last;
  } out_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL,
    ST_OUT
  } state_e;

  localparam logic [31:0] HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Round function of the a word: rotations by 2, 13, 22
  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  // Round function of the e word: rotations by 6, 11, 25
  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  // Schedule function: rotations by 7, 18 and a shift by 3
  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  // Schedule function: rotations by 17, 19 and a shift by 10
  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// ===== src/sha256_byte_stream_hasher_top.sv =====
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_top
// SHA-256 digest of a byte stream, one round per cycle on a shared round unit.
// ----------------------------------------------------------------------------
// An absorb request shifts its byte into a 64-byte block window. The request
// that fills the block starts the compression: 64 rounds on the single round
// unit, one per cycle, then a final step that folds the working words into
// the hash. A finish request writes the padding one byte per cycle up to the
// end of the block (64 minus the bytes held) and compresses, twice when fewer
// than 9 bytes were free, then offers the eight digest words, word 0 first,
// one per output request. The input stalls from the first cycle of any of
// this work until the block is idle again. After the last digest word the
// hash returns to its initial value for the next message.
`default_nettype none

module sha256_byte_stream_hasher_top
  import shabsh_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire in_req_t  in_req_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  output out_req_t      out_req_o
);

  state_e        state_q, state_d;
  logic [5:0]    fill_q, fill_d;
  logic [5:0]    rnd_q, rnd_d;
  logic [2:0]    word_q, word_d;
  logic [60:0]   bytes_q, bytes_d;
  logic [63:0]   len_q, len_d;
  logic          marker_q, marker_d;
  logic          len_blk_q, len_blk_d;
  logic          fin_q, fin_d;
  logic [511:0]  win_q, win_d;
  logic [31:0]   v_q [8];
  logic [31:0]   v_d [8];
  logic [31:0]   hash_q [8];
  logic [31:0]   hash_d [8];

  logic [31:0]   t1, t2, w_next;
  logic [7:0]    pad_byte;
  logic          len_phase;

  // Round unit and schedule expansion on fixed window taps
  always_comb begin
    t1 = v_q[7] + big_sigma1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
         + ROUND_K[rnd_q] + win_q[511:480];
    t2 = big_sigma0(v_q[0])
         + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
    w_next = win_q[511:480] + small_sigma0(win_q[479:448]) + win_q[223:192]
             + small_sigma1(win_q[63:32]);
  end

  // Padding byte: marker first, then zeros, then the bit length
  always_comb begin
    len_phase = len_blk_q && (fill_q >= LEN_POS);
    if (marker_q) begin
      pad_byte = PAD_MARKER;
    end else if (len_phase) begin
      pad_byte = len_q[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d   = state_q;
    fill_d    = fill_q;
    rnd_d     = rnd_q;
    word_d    = word_q;
    bytes_d   = bytes_q;
    len_d     = len_q;
    marker_d  = marker_q;
    len_blk_d = len_blk_q;
    fin_d     = fin_q;
    win_d     = win_q;
    v_d       = v_q;
    hash_d    = hash_q;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (in_req_i.cmd == CMD_ABSORB) begin
            win_d   = {win_q[503:0], in_req_i.data_byte};
            fill_d  = fill_q + 6'd1;
            bytes_d = bytes_q + 61'd1;
            fin_d   = 1'b0;
            if (fill_q == LAST_BYTE) begin
              v_d     = hash_q;
              rnd_d   = '0;
              state_d = ST_ROUND;
            end
          end else begin
            len_d     = {bytes_q, 3'b000};
            bytes_d   = '0;
            marker_d  = 1'b1;
            len_blk_d = (fill_q < LEN_POS);
            fin_d     = 1'b1;
            state_d   = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        win_d    = {win_q[503:0], pad_byte};
        fill_d   = fill_q + 6'd1;
        marker_d = 1'b0;
        if (!marker_q && len_phase) begin
          len_d = {len_q[55:0], 8'h00};
        end
        if (fill_q == LAST_BYTE) begin
          v_d     = hash_q;
          rnd_d   = '0;
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        v_d[0] = t1 + t2;
        v_d[1] = v_q[0];
        v_d[2] = v_q[1];
        v_d[3] = v_q[2];
        v_d[4] = v_q[3] + t1;
        v_d[5] = v_q[4];
        v_d[6] = v_q[5];
        v_d[7] = v_q[6];
        win_d  = {win_q[479:0], w_next};
        rnd_d  = rnd_q + 6'd1;
        if (rnd_q == LAST_ROUND) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + v_q[i];
        end
        if (!fin_q) begin
          state_d = ST_IDLE;
        end else if (len_blk_q) begin
          word_d  = '0;
          state_d = ST_OUT;
        end else begin
          // extra block: zeros up to the length field, then the length
          len_blk_d = 1'b1;
          state_d   = ST_PAD;
        end
      end
      ST_OUT: begin
        if (!out_stall_i) begin
          word_d = word_q + 3'd1;
          if (word_q == LAST_WORD) begin
            hash_d  = HASH_INIT;
            fin_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control and hash state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      rnd_q     <= '0;
      word_q    <= '0;
      bytes_q   <= '0;
      marker_q  <= 1'b0;
      len_blk_q <= 1'b0;
      fin_q     <= 1'b0;
      hash_q    <= HASH_INIT;
    end else begin
      state_q   <= state_d;
      fill_q    <= fill_d;
      rnd_q     <= rnd_d;
      word_q    <= word_d;
      bytes_q   <= bytes_d;
      marker_q  <= marker_d;
      len_blk_q <= len_blk_d;
      fin_q     <= fin_d;
      hash_q    <= hash_d;
    end
  end

  // Block window, working words and captured length
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    v_q   <= v_d;
    len_q <= len_d;
  end

  // Drive the handshake and the digest word
  assign in_stall_o            = (state_q != ST_IDLE);
  assign out_valid_o           = (state_q == ST_OUT);
  assign out_req_o.digest_word = hash_q[word_q];
  assign out_req_o.word_last   = (word_q == LAST_WORD);

endmodule

`default_nettype wire
